### src/mme_pkg.sv
`default_nettype none

package mme_pkg;

    // Array geometry and element format
    localparam int MAX_DIM    = 4;
    localparam int ELEM_WIDTH = 16;
    localparam int IDX_W      = 2;
    localparam int CELL_W     = 2 * IDX_W;
    localparam int CELLS      = MAX_DIM * MAX_DIM;
    localparam int MUL_W      = 2 * ELEM_WIDTH;
    localparam int PROD_W     = 40;
    localparam int DIM_REG_W  = 3;
    localparam int CFG_IDX_W  = 2;

    // Stream widths
    localparam int OP_W         = 2;
    localparam int IN_FIELDS_W  = 2 * IDX_W + ELEM_WIDTH;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * IDX_W + PROD_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_MULT   = 2'd2;

    // Error codes
    localparam logic ERR_NONE     = 1'b0;
    localparam logic ERR_MISMATCH = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 2'd3;

    localparam logic [DIM_REG_W-1:0] DIM_RESET = 3'd4;

    // Store write request, one load at a time
    typedef struct packed {
        logic                  a_en;
        logic                  b_en;
        logic [CELL_W-1:0]     addr;
        logic [ELEM_WIDTH-1:0] data;
    } t_wr_req;

    // Store read request, one entry of each store
    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] addr_a;
        logic [CELL_W-1:0] addr_b;
    } t_rd_req;

    // Control that travels beside each read through the pipeline
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             lastk;
        logic             lastel;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

    // One result item
    typedef struct packed {
        logic              err;
        logic              last;
        logic [PROD_W-1:0] value;
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  row;
    } t_result;

    // Highest index in use for a dimension register: the register is
    // saturated into 1..MAX_DIM first, so zero behaves as one.
    function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_REG_W-1:0] reg_val);
        logic [DIM_REG_W-1:0] sat;
        begin
            if (reg_val == '0) begin
                sat = DIM_REG_W'(1);
            end else if (reg_val > DIM_REG_W'(MAX_DIM)) begin
                sat = DIM_REG_W'(MAX_DIM);
            end else begin
                sat = reg_val;
            end
            dim_last = IDX_W'(sat - DIM_REG_W'(1));
        end
    endfunction

endpackage

`default_nettype wire

### src/mme_store.sv
`default_nettype none

// Element stores for A and B: one write port shared by the loads and one
// registered read port on each store, with data held while reads are off.
module mme_store (
    input  wire logic                          i_clk,
    input  wire mme_pkg::t_wr_req              i_wr,
    input  wire mme_pkg::t_rd_req              i_rd,
    output logic [mme_pkg::ELEM_WIDTH-1:0]     o_a,
    output logic [mme_pkg::ELEM_WIDTH-1:0]     o_b
);

    logic [mme_pkg::ELEM_WIDTH-1:0] r_a_mem [mme_pkg::CELLS];
    logic [mme_pkg::ELEM_WIDTH-1:0] r_b_mem [mme_pkg::CELLS];
    logic [mme_pkg::ELEM_WIDTH-1:0] r_a_data;
    logic [mme_pkg::ELEM_WIDTH-1:0] r_b_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.a_en) begin
            r_a_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_wr.b_en) begin
            r_b_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_a_data <= r_a_mem[i_rd.addr_a];
            r_b_data <= r_b_mem[i_rd.addr_b];
        end
    end

    assign o_a = r_a_data;
    assign o_b = r_b_data;

endmodule

`default_nettype wire

### src/mme_mac.sv
`default_nettype none

// Shared multiply-accumulate unit: a registered product stage followed by
// the accumulator. The whole unit holds when i_adv is low.
module mme_mac (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire mme_pkg::t_tag                 i_tag,
    input  wire logic [mme_pkg::ELEM_WIDTH-1:0] i_a,
    input  wire logic [mme_pkg::ELEM_WIDTH-1:0] i_b,
    output logic                               o_busy,
    output logic                               o_res_vld,
    output mme_pkg::t_result                   o_res
);

    mme_pkg::t_tag                   r_tag;
    logic signed [mme_pkg::MUL_W-1:0] r_prod;
    logic [mme_pkg::PROD_W-1:0]      r_acc;
    logic [mme_pkg::PROD_W-1:0]      w_prod_ext;
    logic [mme_pkg::PROD_W-1:0]      w_base;
    logic [mme_pkg::PROD_W-1:0]      w_sum;

    // Product stage
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= $signed(i_a) * $signed(i_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_adv) begin
            r_tag <= i_tag;
        end
    end

    // Accumulate stage: the first term of each element restarts the sum
    assign w_prod_ext = {{(mme_pkg::PROD_W - mme_pkg::MUL_W){r_prod[mme_pkg::MUL_W-1]}}, r_prod};
    assign w_base     = r_tag.first ? '0 : r_acc;
    assign w_sum      = w_base + w_prod_ext;

    always_ff @(posedge i_clk) begin
        if (i_adv && r_tag.vld) begin
            r_acc <= w_sum;
        end
    end

    // A finished element leaves on the same cycle as its last term
    assign o_busy    = r_tag.vld;
    assign o_res_vld = r_tag.vld && r_tag.lastk;

    always_comb begin
        o_res       = '0;
        o_res.row   = r_tag.row;
        o_res.col   = r_tag.col;
        o_res.value = w_sum;
        o_res.last  = r_tag.lastel;
        o_res.err   = mme_pkg::ERR_NONE;
    end

endmodule

`default_nettype wire

### src/matrix_multiply_engine.sv
// A load item gives no result. A multiply issues one multiply-accumulate per
// cycle unless the output stalls, on a single shared unit and store read port:
// rows x cols x inner of them (up to 64), the last result passing the read,
// product and output registers; a dimension mismatch gives its result via ST_ERR.
// Input is taken only between items; stalls on the output freeze the pipeline.
// Reset sets every dimension register to 4 and clears control; stores keep data.
`default_nettype none

module matrix_multiply_engine (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [mme_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  wire logic [mme_pkg::DIM_REG_W-1:0]      i_cfg_data,
    // Input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: row_index[1:0], col_index[3:2], element_value[19:4], zero pad
    input  wire logic [mme_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: opcode[1:0]
    input  wire logic [mme_pkg::OP_W-1:0]           s_axis_tuser,
    // Output stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata: out_row[1:0], out_col[3:2], product_value[43:4], zero pad
    output logic [mme_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    output logic                                    m_axis_tlast,
    // tuser: error_code[0]
    output logic                                    m_axis_tuser
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_ERR   = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [mme_pkg::DIM_REG_W-1:0]   r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [mme_pkg::IDX_W-1:0]       r_i, r_j, r_k, n_i, n_j, n_k;
    mme_pkg::t_tag                   r_s1, w_issue;
    mme_pkg::t_result                r_out, n_out;
    logic                            r_out_valid, n_out_valid;
    mme_pkg::t_wr_req                w_wr;
    mme_pkg::t_rd_req                w_rd;
    mme_pkg::t_result                w_res;
    logic                            w_res_vld;
    logic                            w_s2_busy;
    logic [mme_pkg::ELEM_WIDTH-1:0]  w_a, w_b;
    logic                            w_adv;
    logic                            w_in_xfer;
    logic [mme_pkg::OP_W-1:0]        w_op;
    logic [mme_pkg::IDX_W-1:0]       w_row, w_col;
    logic [mme_pkg::ELEM_WIDTH-1:0]  w_val;
    logic [mme_pkg::IDX_W-1:0]       w_n_last, w_m_last, w_q_last, w_p_last;
    logic                            w_mismatch;
    logic                            w_k_end, w_j_end, w_i_end;

    // Input fields
    assign w_op      = s_axis_tuser;
    assign w_row     = s_axis_tdata[mme_pkg::IDX_W-1:0];
    assign w_col     = s_axis_tdata[2*mme_pkg::IDX_W-1:mme_pkg::IDX_W];
    assign w_val     = s_axis_tdata[mme_pkg::IN_FIELDS_W-1:2*mme_pkg::IDX_W];
    assign w_in_xfer = s_axis_tvalid && s_axis_tready;

    // The pipeline advances whenever the output register can take a result
    assign w_adv = !r_out_valid || m_axis_tready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= mme_pkg::DIM_RESET;
            r_a_cols <= mme_pkg::DIM_RESET;
            r_b_rows <= mme_pkg::DIM_RESET;
            r_b_cols <= mme_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mme_pkg::CFG_A_ROWS: r_a_rows <= i_cfg_data;
                mme_pkg::CFG_A_COLS: r_a_cols <= i_cfg_data;
                mme_pkg::CFG_B_ROWS: r_b_rows <= i_cfg_data;
                mme_pkg::CFG_B_COLS: r_b_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Saturated dimensions as last indexes
    assign w_n_last   = mme_pkg::dim_last(r_a_rows);
    assign w_m_last   = mme_pkg::dim_last(r_a_cols);
    assign w_q_last   = mme_pkg::dim_last(r_b_rows);
    assign w_p_last   = mme_pkg::dim_last(r_b_cols);
    assign w_mismatch = (w_m_last != w_q_last);

    // Loads are taken only between multiplies, so a read never meets a write
    // to the same entry in flight.
    always_comb begin
        w_wr      = '0;
        w_wr.addr = {w_row, w_col};
        w_wr.data = w_val;
        w_wr.a_en = w_in_xfer && (w_op == mme_pkg::OP_LOAD_A);
        w_wr.b_en = w_in_xfer && (w_op == mme_pkg::OP_LOAD_B);
    end

    // Read addresses: A[i][k] and B[k][j]
    always_comb begin
        w_rd        = '0;
        w_rd.en     = w_adv;
        w_rd.addr_a = {r_i, r_k};
        w_rd.addr_b = {r_k, r_j};
    end

    assign w_k_end = (r_k == w_m_last);
    assign w_j_end = (r_j == w_p_last);
    assign w_i_end = (r_i == w_n_last);

    always_comb begin
        w_issue        = '0;
        w_issue.vld    = (r_state == ST_RUN);
        w_issue.first  = (r_k == '0);
        w_issue.lastk  = w_k_end;
        w_issue.lastel = w_k_end && w_j_end && w_i_end;
        w_issue.row    = r_i;
        w_issue.col    = r_j;
    end

    mme_store u_store (
        .i_clk (i_clk),
        .i_wr  (w_wr),
        .i_rd  (w_rd),
        .o_a   (w_a),
        .o_b   (w_b)
    );

    // Tag that lines up with the registered read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (w_adv) begin
            r_s1 <= w_issue;
        end
    end

    mme_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_tag     (r_s1),
        .i_a       (w_a),
        .i_b       (w_b),
        .o_busy    (w_s2_busy),
        .o_res_vld (w_res_vld),
        .o_res     (w_res)
    );

    // Sequencer: walks i, j, k with k innermost
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        case (r_state)
            ST_IDLE: begin
                n_i = '0;
                n_j = '0;
                n_k = '0;
                if (w_in_xfer && (w_op == mme_pkg::OP_MULT)) begin
                    n_state = w_mismatch ? ST_ERR : ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_adv) begin
                    if (!w_k_end) begin
                        n_k = r_k + 1'b1;
                    end else begin
                        n_k = '0;
                        if (!w_j_end) begin
                            n_j = r_j + 1'b1;
                        end else begin
                            n_j = '0;
                            if (!w_i_end) begin
                                n_i = r_i + 1'b1;
                            end else begin
                                n_state = ST_DRAIN;
                            end
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (!r_s1.vld && !w_s2_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (w_adv) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    // Output register: a finished element or the mismatch result
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_adv && w_res_vld) begin
            n_out       = w_res;
            n_out_valid = 1'b1;
        end else if (w_adv && (r_state == ST_ERR)) begin
            n_out       = '0;
            n_out.last  = 1'b1;
            n_out.err   = mme_pkg::ERR_MISMATCH;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Ports
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(mme_pkg::OUT_TDATA_W - mme_pkg::OUT_FIELDS_W){1'b0}},
                            r_out.value, r_out.col, r_out.row};
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tuser  = r_out.err;

    // The pipeline is empty whenever a new item can be taken
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_s1.vld && !w_s2_busy))
        else $error("pipeline not empty while taking input");

    // A mismatch result always closes its multiply
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == mme_pkg::ERR_MISMATCH)) |-> m_axis_tlast)
        else $error("error result without last");

    // A multiply with mismatched inner dimensions goes to the error state
    a_mismatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (w_op == mme_pkg::OP_MULT) && w_mismatch) |=> (r_state == ST_ERR))
        else $error("mismatch not reported");

    // A finished element never arrives while the output register is blocked
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> $stable(r_out))
        else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

### tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mme_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES = 20;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES = 9;
    localparam int ITEMS_PER_PHASE = 35;

    // One input item and one product element, as the fields of the streams
    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [IDX_W-1:0]      row;
        logic [IDX_W-1:0]      col;
        logic [ELEM_WIDTH-1:0] value;
    } mm_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [PROD_W-1:0] value;
        logic              last;
        logic              err;
    } product_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [DIM_REG_W-1:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic [OP_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic m_axis_tuser;

    // Items waiting to be offered and product elements still to arrive
    mm_item_t pending_items[$];
    product_t product_q[$];

    // Own copy of the dimension registers and of both element stores
    logic [DIM_REG_W-1:0] dim_reg[4];
    logic [ELEM_WIDTH-1:0] a_mem[CELLS];
    logic [ELEM_WIDTH-1:0] b_mem[CELLS];
    // Entries already loaded by queued items, so that no multiply reads a blank one
    bit a_loaded[CELLS];
    bit b_loaded[CELLS];

    mm_item_t cur_item;
    int items_accepted = 0;
    int mismatches = 0;
    int cycle_cnt = 0;
    int send_idle_pct = 30;
    int recv_idle_pct = 84;
    bit hold_arm = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    matrix_multiply_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // A dimension register is used after saturation into 1..MAX_DIM.
    function automatic int clamp_dim(input logic [DIM_REG_W-1:0] v);
        if (v == '0) begin
            return 1;
        end else if (v > DIM_REG_W'(MAX_DIM)) begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    // Element values lean towards the extremes of signed Q8.8.
    function automatic logic [ELEM_WIDTH-1:0] pick_element();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return ELEM_WIDTH'($urandom());
        endcase
    endfunction

    // Store update on a load, or the full list of product elements on a multiply.
    task automatic apply_item(input mm_item_t it);
        int n, m, p, i, j, k;
        logic signed [MUL_W-1:0] prod;
        logic signed [PROD_W-1:0] acc;
        product_t r;
        case (it.op)
            OP_LOAD_A: a_mem[int'(it.row) * MAX_DIM + int'(it.col)] = it.value;
            OP_LOAD_B: b_mem[int'(it.row) * MAX_DIM + int'(it.col)] = it.value;
            OP_MULT: begin
                n = clamp_dim(dim_reg[CFG_A_ROWS]);
                m = clamp_dim(dim_reg[CFG_A_COLS]);
                p = clamp_dim(dim_reg[CFG_B_COLS]);
                if (m != clamp_dim(dim_reg[CFG_B_ROWS])) begin
                    r = '0;
                    r.last = 1'b1;
                    r.err = ERR_MISMATCH;
                    product_q.push_back(r);
                end else begin
                    for (i = 0; i < n; i++) begin
                        for (j = 0; j < p; j++) begin
                            acc = '0;
                            for (k = 0; k < m; k++) begin
                                prod = $signed(a_mem[i * MAX_DIM + k])
                                     * $signed(b_mem[k * MAX_DIM + j]);
                                acc = acc + {{(PROD_W - MUL_W){prod[MUL_W-1]}}, prod};
                            end
                            r.row = IDX_W'(i);
                            r.col = IDX_W'(j);
                            r.value = acc;
                            r.last = (i == n - 1) && (j == p - 1);
                            r.err = ERR_NONE;
                            product_q.push_back(r);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Sender: a new item is offered once the previous one has made its transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_item(cur_item);
                items_accepted <= items_accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= IN_TDATA_W'({cur_item.value, cur_item.col, cur_item.row});
                    s_axis_tuser <= cur_item.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold once armed.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Each output transfer is checked against the oldest expected element.
    always @(posedge i_clk) begin
        product_t got;
        product_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.row = m_axis_tdata[IDX_W-1:0];
            got.col = m_axis_tdata[2*IDX_W-1:IDX_W];
            got.value = m_axis_tdata[2*IDX_W+PROD_W-1:2*IDX_W];
            got.last = m_axis_tlast;
            got.err = m_axis_tuser;
            if (product_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: actual row %0d col %0d value %0d last %0b err %0b",
                         $time, got.row, got.col, $signed(got.value), got.last, got.err);
            end else begin
                want = product_q.pop_front();
                if (got.row != want.row || got.col != want.col || got.value != want.value ||
                    got.last != want.last || got.err != want.err) begin
                    mismatches++;
                    $display("%0t: mismatch: expected row %0d col %0d value %0d last %0b err %0b",
                             $time, want.row, want.col, $signed(want.value), want.last,
                             want.err);
                    $display("%0t:           actual row %0d col %0d value %0d last %0b err %0b",
                             $time, got.row, got.col, $signed(got.value), got.last, got.err);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Register writes, one per clock; called only while the block is idle.
    task automatic write_dims(input logic [DIM_REG_W-1:0] a_r, input logic [DIM_REG_W-1:0] a_c,
                              input logic [DIM_REG_W-1:0] b_r, input logic [DIM_REG_W-1:0] b_c);
        logic [DIM_REG_W-1:0] vals[4];
        int idx;
        vals = '{a_r, a_c, b_r, b_c};
        for (idx = 0; idx < 4; idx++) begin
            i_cfg_we <= 1'b1;
            i_cfg_addr <= CFG_IDX_W'(idx);
            i_cfg_data <= vals[idx];
            dim_reg[idx] = vals[idx];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_item(input logic [OP_W-1:0] op, input int row, input int col,
                              input logic [ELEM_WIDTH-1:0] value);
        mm_item_t it;
        it.op = op;
        it.row = IDX_W'(row);
        it.col = IDX_W'(col);
        it.value = value;
        if (op == OP_LOAD_A) begin
            a_loaded[row * MAX_DIM + col] = 1'b1;
        end else if (op == OP_LOAD_B) begin
            b_loaded[row * MAX_DIM + col] = 1'b1;
        end
        pending_items.push_back(it);
    endtask

    // A multiply, preceded by loads of any entry it would read that is still blank.
    task automatic queue_multiply();
        int n, m, p, i, j, k;
        n = clamp_dim(dim_reg[CFG_A_ROWS]);
        m = clamp_dim(dim_reg[CFG_A_COLS]);
        p = clamp_dim(dim_reg[CFG_B_COLS]);
        if (m == clamp_dim(dim_reg[CFG_B_ROWS])) begin
            for (i = 0; i < n; i++) begin
                for (k = 0; k < m; k++) begin
                    if (!a_loaded[i * MAX_DIM + k]) begin
                        queue_item(OP_LOAD_A, i, k, pick_element());
                    end
                end
            end
            for (k = 0; k < m; k++) begin
                for (j = 0; j < p; j++) begin
                    if (!b_loaded[k * MAX_DIM + j]) begin
                        queue_item(OP_LOAD_B, k, j, pick_element());
                    end
                end
            end
        end
        queue_item(OP_MULT, $urandom_range(0, 3), $urandom_range(0, 3), pick_element());
    endtask

    // Mostly loads with a multiply now and then, and a few unused opcodes.
    task automatic queue_random(input int count);
        int idx, roll;
        for (idx = 0; idx < count; idx++) begin
            roll = $urandom_range(0, 99);
            if (roll < 14) begin
                queue_multiply();
            end else if (roll < 18) begin
                queue_item(OP_UNUSED, $urandom_range(0, 3), $urandom_range(0, 3),
                           pick_element());
            end else begin
                queue_item($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A,
                           $urandom_range(0, 3), $urandom_range(0, 3), pick_element());
            end
        end
    endtask

    // Waits until every item has made its transfer and every element has come,
    // then lets a trailing load finish inside the block.
    task automatic wait_drained(input int extra);
        forever begin
            @(posedge i_clk);
            #1;
            if (pending_items.size() == 0 && !s_axis_tvalid && product_q.size() == 0) begin
                break;
            end
        end
        repeat (extra) @(posedge i_clk);
    endtask

    initial begin
        int ph, idx;
        logic [DIM_REG_W-1:0] a_r, a_c, b_r, b_c;
        dim_reg = '{DIM_RESET, DIM_RESET, DIM_RESET, DIM_RESET};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest shapes, zero dimension acting as one, extreme elements.
        write_dims(3'd0, 3'd1, 3'd1, 3'd2);
        queue_item(OP_LOAD_A, 0, 0, 16'h8000);
        queue_item(OP_LOAD_B, 0, 0, 16'h8000);
        queue_item(OP_LOAD_B, 0, 1, 16'h7FFF);
        queue_multiply();
        queue_item(OP_UNUSED, 3, 3, 16'hFFFF);
        queue_item(OP_LOAD_A, 3, 3, 16'h7FFF);
        queue_item(OP_LOAD_B, 3, 3, 16'h8000);
        queue_item(OP_LOAD_A, 0, 0, 16'h7FFF);
        queue_multiply();
        wait_drained(SETTLE_CYCLES);

        // Inner dimensions that disagree give a single error result.
        write_dims(3'd7, 3'd2, 3'd3, 3'd7);
        queue_multiply();
        queue_item(OP_LOAD_B, 2, 1, 16'h0000);
        queue_multiply();
        wait_drained(SETTLE_CYCLES);

        // Oversized column count saturates to four and matches; largest sums.
        write_dims(3'd4, 3'd7, 3'd4, 3'd4);
        for (idx = 0; idx < CELLS; idx++) begin
            queue_item(OP_LOAD_A, idx / MAX_DIM, idx % MAX_DIM, 16'h8000);
            queue_item(OP_LOAD_B, idx / MAX_DIM, idx % MAX_DIM, 16'h8000);
        end
        queue_multiply();
        queue_item(OP_LOAD_B, 1, 2, 16'h7FFF);
        queue_multiply();
        wait_drained(SETTLE_CYCLES);

        // Zero inner count acts as one and matches a single row of B.
        write_dims(3'd2, 3'd0, 3'd1, 3'd3);
        queue_multiply();
        wait_drained(SETTLE_CYCLES);

        // Random phases: idling on the receiver, then on the sender, then none.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 30;
                recv_idle_pct = 84;
            end else if (ph < 6) begin
                send_idle_pct = 84;
                recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            a_r = DIM_REG_W'($urandom_range(0, 7));
            a_c = DIM_REG_W'($urandom_range(0, 7));
            b_r = ($urandom_range(0, 4) != 0) ? a_c : DIM_REG_W'($urandom_range(0, 7));
            b_c = DIM_REG_W'($urandom_range(0, 7));
            write_dims(a_r, a_c, b_r, b_c);
            if (ph == 6) begin
                // Several multiplies queue up behind a long receiver hold.
                queue_multiply();
                queue_multiply();
                queue_multiply();
                hold_arm = 1'b1;
            end
            queue_random(ITEMS_PER_PHASE);
            wait_drained(SETTLE_CYCLES);
        end

        wait_drained(TAIL_CYCLES);
        if (mismatches == 0 && product_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
